FILE: rtl/multi_slot_timer_table_top_defines.svh
// Assertion macros shared by the timer table modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef MULTI_SLOT_TIMER_TABLE_TOP_DEFINES_SVH
`define MULTI_SLOT_TIMER_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mstt_pkg.sv
package mstt_pkg;

	localparam int DEF_SLOTS       = 16;
	localparam int DEF_ID_WIDTH    = 32;
	localparam int DEF_TIME_WIDTH  = 32;
	localparam int DEF_COUNT_WIDTH = 16;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_ONESHOT  = 2'd1,
		REQ_PERIODIC = 2'd2,
		REQ_DISARM   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		KIND_ARMED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_DISARMED  = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED     = 3'd4
	} kind_t;

	// What the controller asks the datapath to place in the output register.
	typedef enum logic [2:0] {
		PUSH_NONE,
		PUSH_ARMED,
		PUSH_FULL,
		PUSH_DISARM,
		PUSH_LAST
	} push_t;

	typedef struct packed {
		logic  load;      // capture the request payload
		logic  rd_en;     // read the slot row at the scan index
		logic  ev_commit; // retire the slot row held in the evaluate stage
		push_t push;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_is_arm;  // request at the input port arms a timer
		logic is_tick;    // captured request is a tick
		logic active_idx; // slot at the scan index is active
		logic ev_block;   // evaluated slot must emit but has nowhere to go
		logic pend_vld;   // a fired result is held back for the last flag
		logic out_free;   // output register can take a result this cycle
	} dp_stat_t;

endpackage

FILE: rtl/mstt_in_if.sv
interface mstt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] delay_ticks;
	logic [15:0] repeat_count;
	logic [31:0] timer_id;

	modport source (output valid, output req_type, output delay_ticks,
		output repeat_count, output timer_id, input ready);
	modport sink (input valid, input req_type, input delay_ticks,
		input repeat_count, input timer_id, output ready);
endinterface

FILE: rtl/mstt_out_if.sv
interface mstt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [31:0] result_id;
	logic        last;

	modport source (output valid, output result_kind, output result_id,
		output last, input ready);
	modport sink (input valid, input result_kind, input result_id,
		input last, output ready);
endinterface

FILE: rtl/multi_slot_timer_table_top.sv
// Channel  Modport  Payload                                          Results per request
// req      sink     req_type, delay_ticks, repeat_count, timer_id    -
// rsp      source   result_kind, result_id, last                     0 to SLOTS
//
// On arm the controller walks the active bits to the first free slot.
// Tick and disarm scan one slot per cycle unless stalled; only active slot rows are read from the slot RAM.
// Reset clears every active bit and sets the next identifier to one; the slot RAM is not cleared.
// A fired result waits in a holding register until the next one or the end of the scan, which
// sets its last flag; the scan stalls when a slot fires while that register and the output register are both full.

module multi_slot_timer_table_top import mstt_pkg::*; #(
	parameter int SLOTS       = DEF_SLOTS,
	parameter int ID_WIDTH    = DEF_ID_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mstt_in_if.sink   req,
	mstt_out_if.source rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Commands flow from the controller into the datapath, status flows back.
	ctl_cmd_t      cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_idx;
	logic [AW-1:0] ev_idx;

	// The controller owns the request handshake and the scan sequence. A request is
	// taken only in its idle state, so the payload is captured once per request.
	mstt_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd),
		.rd_idx  (rd_idx),
		.ev_idx  (ev_idx)
	);

	// The datapath holds the slot table, the identifier counter, the held fired
	// result and the output register that drives the result channel.
	mstt_dp #(
		.SLOTS      (SLOTS),
		.ID_WIDTH   (ID_WIDTH),
		.TIME_WIDTH (TIME_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_req_type    (req.req_type),
		.in_delay_ticks (req.delay_ticks),
		.in_repeat_count(req.repeat_count),
		.in_timer_id    (req.timer_id),
		.cmd            (cmd),
		.rd_idx         (rd_idx),
		.ev_idx         (ev_idx),
		.stat           (stat),
		.rsp            (rsp)
	);

endmodule

FILE: rtl/mstt_ram.sv
module mstt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mstt_ctrl.sv
`include "multi_slot_timer_table_top_defines.svh"

module mstt_ctrl import mstt_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  dp_stat_t                               stat,
	output ctl_cmd_t                               cmd,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ev_idx
);

	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ARM  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             ev_vld_s1, ev_vld_d;
	logic [AW-1:0]    ev_idx_s1;
	logic             rd_done;
	logic             stall;

	assign rd_done = (idx_q == SLOTS_C);
	assign stall   = ev_vld_s1 && stat.ev_block;
	assign rd_idx  = idx_q[AW-1:0];
	assign ev_idx  = ev_idx_s1;

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		ev_vld_d      = 1'b0;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.rd_en     = 1'b0;
		cmd.ev_commit = 1'b0;
		cmd.push      = PUSH_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = stat.in_is_arm ? ST_ARM : ST_SCAN;
				end
			end
			ST_ARM: begin
				// Walk the active bits until the first free slot.
				if (rd_done) begin
					if (stat.out_free) begin
						cmd.push = PUSH_FULL;
						state_d  = ST_IDLE;
					end
				end else if (!stat.active_idx) begin
					if (stat.out_free) begin
						cmd.push = PUSH_ARMED;
						state_d  = ST_IDLE;
					end
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_SCAN: begin
				// Read stage at idx_q overlaps the evaluate stage of the slot before it.
				if (stall) begin
					ev_vld_d = 1'b1;
				end else begin
					cmd.ev_commit = ev_vld_s1;
					ev_vld_d      = !rd_done && stat.active_idx;
					cmd.rd_en     = ev_vld_d;
					if (rd_done) begin
						state_d = ST_FIN;
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
			end
			ST_FIN: begin
				if (stat.is_tick) begin
					if (!stat.pend_vld) begin
						state_d = ST_IDLE;
					end else if (stat.out_free) begin
						cmd.push = PUSH_LAST;
						state_d  = ST_IDLE;
					end
				end else if (stat.out_free) begin
					cmd.push = PUSH_DISARM;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			ev_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			ev_vld_s1 <= ev_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ev_idx_s1 <= idx_q[AW-1:0];
		end
	end

	`MSTT_ASSERT_NOW(a_idle_no_eval, state_q == ST_IDLE, !ev_vld_s1, "evaluate stage busy while idle")
	`MSTT_ASSERT_NOW(a_eval_in_scan, ev_vld_s1, state_q == ST_SCAN, "evaluate stage busy outside scan")
	`MSTT_ASSERT_NEXT(a_stall_holds_idx, stall, $stable(idx_q), "scan index moved during a stall")

endmodule

FILE: rtl/mstt_dp.sv
`include "multi_slot_timer_table_top_defines.svh"

module mstt_dp import mstt_pkg::*; #(
	parameter int SLOTS       = DEF_SLOTS,
	parameter int ID_WIDTH    = DEF_ID_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [1:0]                             in_req_type,
	input  logic [31:0]                            in_delay_ticks,
	input  logic [15:0]                            in_repeat_count,
	input  logic [31:0]                            in_timer_id,
	input  ctl_cmd_t                               cmd,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ev_idx,
	output dp_stat_t                               stat,
	mstt_out_if.source                             rsp
);

	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROW_W = ID_WIDTH + 2 * TIME_WIDTH + 2 * COUNT_WIDTH;

	typedef struct packed {
		logic [ID_WIDTH-1:0]    ident;
		logic [TIME_WIDTH-1:0]  remaining;
		logic [TIME_WIDTH-1:0]  period;
		logic [COUNT_WIDTH-1:0] limit;
		logic [COUNT_WIDTH-1:0] fired;
	} row_t;

	req_type_t              type_q;
	logic [TIME_WIDTH-1:0]  delay_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [ID_WIDTH-1:0]    tid_q;
	logic                   hit_q;
	logic [ID_WIDTH-1:0]    next_id_q;
	logic [SLOTS-1:0]       active_q;
	logic                   pend_vld_q;
	logic [ID_WIDTH-1:0]    pend_id_q;
	logic                   out_vld_q;
	kind_t                  out_kind_q;
	logic [31:0]            out_id_q;
	logic                   out_last_q;

	logic [ROW_W-1:0]       ram_rdata;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	row_t                   ram_wrow;
	row_t                   ev_row;
	row_t                   arm_row;
	row_t                   tick_row;
	logic [TIME_WIDTH-1:0]  rem_dec;
	logic [COUNT_WIDTH-1:0] fired_inc;
	logic                   fire;
	logic                   reload;
	logic                   match;
	logic                   is_tick;
	logic                   is_periodic;
	logic                   out_free;
	logic                   emit_ok;
	logic                   ev_emit;
	logic                   out_load;
	kind_t                  out_kind_d;
	logic [31:0]            out_id_d;
	logic                   out_last_d;

	assign ev_row      = row_t'(ram_rdata);
	assign is_tick     = (type_q == REQ_TICK);
	assign is_periodic = (type_q == REQ_PERIODIC);

	// Slot evaluation on a tick: count down, saturating, then fire and reload or retire.
	assign rem_dec   = (ev_row.remaining != '0) ? ev_row.remaining - TIME_WIDTH'(1) : '0;
	assign fire      = (rem_dec == '0);
	assign fired_inc = (ev_row.fired != '1) ? ev_row.fired + COUNT_WIDTH'(1) : ev_row.fired;
	assign reload    = (ev_row.period != '0) &&
		((ev_row.limit == '0) || (fired_inc < ev_row.limit));
	assign match     = (ev_row.ident == tid_q);

	assign out_free = !out_vld_q || rsp.ready;
	assign emit_ok  = !pend_vld_q || out_free;
	assign ev_emit  = cmd.ev_commit && is_tick && fire;

	always_comb begin
		tick_row           = ev_row;
		tick_row.remaining = (fire && reload) ? ev_row.period : rem_dec;
		tick_row.fired     = fire ? fired_inc : ev_row.fired;

		arm_row.ident     = next_id_q;
		arm_row.remaining = delay_q;
		arm_row.period    = is_periodic ? delay_q : '0;
		arm_row.limit     = is_periodic ? count_q : COUNT_WIDTH'(1);
		arm_row.fired     = '0;
	end

	assign ram_we    = (cmd.ev_commit && is_tick) || (cmd.push == PUSH_ARMED);
	assign ram_waddr = (cmd.push == PUSH_ARMED) ? rd_idx : ev_idx;
	assign ram_wrow  = (cmd.push == PUSH_ARMED) ? arm_row : tick_row;

	mstt_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wrow),
		.re   (cmd.rd_en),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_FIRED;
		out_id_d   = 32'(pend_id_q);
		out_last_d = 1'b1;
		unique case (cmd.push)
			PUSH_ARMED: begin
				out_load   = 1'b1;
				out_kind_d = KIND_ARMED;
				out_id_d   = 32'(next_id_q);
			end
			PUSH_FULL: begin
				out_load   = 1'b1;
				out_kind_d = KIND_FULL;
				out_id_d   = '0;
			end
			PUSH_DISARM: begin
				out_load   = 1'b1;
				out_kind_d = hit_q ? KIND_DISARMED : KIND_NOT_FOUND;
				out_id_d   = 32'(tid_q);
			end
			PUSH_LAST: begin
				out_load = 1'b1;
			end
			PUSH_NONE: begin
				// A newer firing pushes the held one out, which therefore is not last.
				out_load   = ev_emit && pend_vld_q;
				out_last_d = 1'b0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q     <= REQ_TICK;
			hit_q      <= 1'b0;
			next_id_q  <= ID_WIDTH'(1);
			active_q   <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				type_q <= req_type_t'(in_req_type);
				hit_q  <= 1'b0;
			end
			if (cmd.push == PUSH_ARMED) begin
				active_q[rd_idx] <= 1'b1;
				next_id_q        <= next_id_q + ID_WIDTH'(1);
			end
			if (cmd.ev_commit) begin
				if (is_tick) begin
					if (fire && !reload) begin
						active_q[ev_idx] <= 1'b0;
					end
				end else if (match) begin
					active_q[ev_idx] <= 1'b0;
					hit_q            <= 1'b1;
				end
			end
			if (ev_emit) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.push == PUSH_LAST) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delay_q <= TIME_WIDTH'(in_delay_ticks);
			count_q <= COUNT_WIDTH'(in_repeat_count);
			tid_q   <= ID_WIDTH'(in_timer_id);
		end
		if (ev_emit) begin
			pend_id_q <= ev_row.ident;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_id_q   <= out_id_d;
			out_last_q <= out_last_d;
		end
	end

	assign stat.in_is_arm  = (req_type_t'(in_req_type) == REQ_ONESHOT) ||
		(req_type_t'(in_req_type) == REQ_PERIODIC);
	assign stat.is_tick    = is_tick;
	assign stat.active_idx = active_q[rd_idx];
	assign stat.ev_block   = is_tick && fire && !emit_ok;
	assign stat.pend_vld   = pend_vld_q;
	assign stat.out_free   = out_free;

	assign rsp.valid       = out_vld_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.result_id   = out_id_q;
	assign rsp.last        = out_last_q;

	`MSTT_ASSERT_NOW(a_push_into_free, cmd.push != PUSH_NONE, out_free, "result pushed into a full output register")
	`MSTT_ASSERT_NOW(a_emit_has_room, ev_emit, emit_ok, "fired result committed without room")
	`MSTT_ASSERT_NOW(a_load_no_pending, cmd.load, !pend_vld_q, "request accepted with a held result")

endmodule
